/* design/tcr_pkg.sv */
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared types and constants of the text console renderer.
// ----------------------------------------------------------------------------
package tcr_pkg;

	localparam int ADDR_W      = 20;
	localparam int CODE_W      = 8;
	localparam int LINE_W      = 4;
	localparam int GLYPH_WIDTH = 8;
	localparam int STORE_DEPTH = 1 << (CODE_W + LINE_W);

	localparam logic [CODE_W-1:0] CODE_BS = 8'd8;
	localparam logic [CODE_W-1:0] CODE_NL = 8'd10;
	localparam logic [CODE_W-1:0] CODE_FF = 8'd12;

	localparam logic KIND_PRINT = 1'b0;
	localparam logic KIND_LOAD  = 1'b1;

	typedef enum logic [1:0] {
		CMD_PAINT  = 2'd0,
		CMD_SCROLL = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	// work handed from the cursor unit to the row sequencer
	typedef struct packed {
		logic              paint;
		logic              blank;
		logic              extra;
		cmd_t              extra_cmd;
		logic [CODE_W-1:0] code;
		logic [ADDR_W-1:0] addr;
	} job_t;

endpackage

/* design/tcr_if.sv */
// ----------------------------------------------------------------------------
// tcr_if
// Request channels of the text console renderer: character/glyph input and
// framebuffer command output.
// ----------------------------------------------------------------------------
interface tcr_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_code;
	logic [3:0] glyph_line;
	logic [7:0] glyph_bits;

	modport source (output valid, kind, char_code, glyph_line, glyph_bits, input ready);
	modport sink   (input valid, kind, char_code, glyph_line, glyph_bits, output ready);
endinterface

interface tcr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [19:0] pixel_address;
	logic [7:0]  row_bits;
	logic        last;

	modport source (output valid, command, pixel_address, row_bits, last, input ready);
	modport sink   (input valid, command, pixel_address, row_bits, last, output ready);
endinterface

/* design/tcr_ram.sv */
// ----------------------------------------------------------------------------
// tcr_ram
// Generic single-clock RAM, one write port, one registered read port.
// Read during write returns the old contents.
// ----------------------------------------------------------------------------
module tcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/tcr_cursor.sv */
// ----------------------------------------------------------------------------
// tcr_cursor
// Text cursor: column, row, row base and pixel address. Works out the paint
// cell and follow-up command of each printed code.
// ----------------------------------------------------------------------------
module tcr_cursor #(
	parameter int SCREEN_PIXELS_WIDE = 1280,
	parameter int SCREEN_PIXELS_HIGH = 720,
	parameter int GLYPH_HEIGHT       = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [tcr_pkg::CODE_W-1:0]  code,
	output tcr_pkg::job_t               job
);

	localparam int A         = tcr_pkg::ADDR_W;
	localparam int TEXT_COLS = SCREEN_PIXELS_WIDE / tcr_pkg::GLYPH_WIDTH;
	localparam int TEXT_ROWS = SCREEN_PIXELS_HIGH / GLYPH_HEIGHT;
	localparam int COL_W     = $clog2(TEXT_COLS);
	localparam int ROW_W     = $clog2(TEXT_ROWS);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(TEXT_COLS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TEXT_ROWS - 1);
	localparam logic [A-1:0] ROW_STRIDE =
		A'((SCREEN_PIXELS_WIDE * GLYPH_HEIGHT) % (1 << A));
	localparam logic [A-1:0] LAST_BASE =
		A'(((TEXT_ROWS - 1) * SCREEN_PIXELS_WIDE * GLYPH_HEIGHT) % (1 << A));
	localparam logic [A-1:0] LAST_COL_OFF =
		A'(((TEXT_COLS - 1) * tcr_pkg::GLYPH_WIDTH) % (1 << A));
	localparam logic [A-1:0] CELL_STEP = A'(tcr_pkg::GLYPH_WIDTH);

	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] row_q, row_d, nl_row;
	logic [A-1:0]     base_q, base_d, nl_base;
	logic [A-1:0]     addr_q, addr_d;
	logic             nl_scroll;

	always_comb begin
		if (row_q == LAST_ROW) begin
			nl_row    = row_q;
			nl_base   = LAST_BASE;
			nl_scroll = 1'b1;
		end else begin
			nl_row    = row_q + 1'b1;
			nl_base   = base_q + ROW_STRIDE;
			nl_scroll = 1'b0;
		end

		col_d  = col_q;
		row_d  = row_q;
		base_d = base_q;
		addr_d = addr_q;

		job.paint     = 1'b0;
		job.blank     = 1'b0;
		job.extra     = 1'b0;
		job.extra_cmd = tcr_pkg::CMD_SCROLL;
		job.code      = code;
		job.addr      = addr_q;

		case (code)
			tcr_pkg::CODE_BS: begin
				if (col_q == '0 && row_q == '0) begin
					job.addr = addr_q;
				end else if (col_q == '0) begin
					col_d  = LAST_COL;
					row_d  = row_q - 1'b1;
					base_d = base_q - ROW_STRIDE;
					addr_d = base_q - ROW_STRIDE + LAST_COL_OFF;
				end else begin
					col_d  = col_q - 1'b1;
					addr_d = addr_q - CELL_STEP;
				end
				job.paint = 1'b1;
				job.blank = 1'b1;
				job.addr  = addr_d;
			end
			tcr_pkg::CODE_NL: begin
				col_d     = '0;
				row_d     = nl_row;
				base_d    = nl_base;
				addr_d    = nl_base;
				job.extra = nl_scroll;
			end
			tcr_pkg::CODE_FF: begin
				col_d         = '0;
				row_d         = '0;
				base_d        = '0;
				addr_d        = '0;
				job.extra     = 1'b1;
				job.extra_cmd = tcr_pkg::CMD_CLEAR;
			end
			default: begin
				job.paint = 1'b1;
				if (col_q == LAST_COL) begin
					col_d     = '0;
					row_d     = nl_row;
					base_d    = nl_base;
					addr_d    = nl_base;
					job.extra = nl_scroll;
				end else begin
					col_d  = col_q + 1'b1;
					addr_d = addr_q + CELL_STEP;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			base_q <= '0;
			addr_q <= '0;
		end else if (take) begin
			col_q  <= col_d;
			row_q  <= row_d;
			base_q <= base_d;
			addr_q <= addr_d;
		end
	end

endmodule

/* design/tcr_seq.sv */
// ----------------------------------------------------------------------------
// tcr_seq
// Row sequencer: steps through the glyph rows of a cell, reads the glyph
// store, and drives the command output through a read stage and an output
// register.
// ----------------------------------------------------------------------------
module tcr_seq #(
	parameter int SCREEN_PIXELS_WIDE = 1280,
	parameter int GLYPH_HEIGHT       = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  tcr_pkg::job_t                               job,
	output logic                                        seq_ready,
	output logic                                        rd_en,
	output logic [tcr_pkg::CODE_W+tcr_pkg::LINE_W-1:0]  rd_addr,
	input  logic [7:0]                                  rd_data,
	tcr_out_if.source                                   result
);

	localparam int A = tcr_pkg::ADDR_W;
	localparam logic [tcr_pkg::LINE_W-1:0] LAST_LINE = tcr_pkg::LINE_W'(GLYPH_HEIGHT - 1);
	localparam logic [A-1:0] LINE_STRIDE = A'(SCREEN_PIXELS_WIDE);

	logic                       paint_q, blank_q, extra_q;
	tcr_pkg::cmd_t              extra_cmd_q;
	logic [tcr_pkg::CODE_W-1:0] code_q;
	logic [tcr_pkg::LINE_W-1:0] cnt_q;
	logic [A-1:0]               addr_q;

	logic                       valid_s1, blank_s1, last_s1;
	tcr_pkg::cmd_t              cmd_s1;
	logic [A-1:0]               addr_s1;

	logic                       res_valid_q, res_last_q;
	logic [1:0]                 res_cmd_q;
	logic [A-1:0]               res_addr_q;
	logic [7:0]                 res_bits_q;

	logic active, take_s1, advance, issue, fin, end_line;

	assign active    = paint_q | extra_q;
	assign take_s1   = !res_valid_q || result.ready;
	assign advance   = !valid_s1 || take_s1;
	assign issue     = active && advance;
	assign end_line  = cnt_q == LAST_LINE;
	assign fin       = issue && ((paint_q && end_line && !extra_q) || (!paint_q && extra_q));
	assign seq_ready = !active || fin;

	assign rd_en   = issue && paint_q;
	assign rd_addr = {code_q, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paint_q <= 1'b0;
			extra_q <= 1'b0;
		end else begin
			if (issue) begin
				if (paint_q) begin
					if (end_line) begin
						paint_q <= 1'b0;
					end
				end else begin
					extra_q <= 1'b0;
				end
			end
			if (start) begin
				paint_q <= job.paint;
				extra_q <= job.extra;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue && paint_q) begin
			cnt_q  <= cnt_q + 1'b1;
			addr_q <= addr_q + LINE_STRIDE;
		end
		if (start) begin
			blank_q     <= job.blank;
			extra_cmd_q <= job.extra_cmd;
			code_q      <= job.code;
			cnt_q       <= '0;
			addr_q      <= job.addr;
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			if (paint_q) begin
				cmd_s1   <= tcr_pkg::CMD_PAINT;
				addr_s1  <= addr_q;
				blank_s1 <= blank_q;
				last_s1  <= end_line && !extra_q;
			end else begin
				cmd_s1   <= extra_cmd_q;
				addr_s1  <= '0;
				blank_s1 <= 1'b1;
				last_s1  <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take_s1) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && valid_s1) begin
			res_cmd_q  <= cmd_s1;
			res_addr_q <= addr_s1;
			res_bits_q <= blank_s1 ? 8'd0 : rd_data;
			res_last_q <= last_s1;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.command       = res_cmd_q;
	assign result.pixel_address = res_addr_q;
	assign result.row_bits      = res_bits_q;
	assign result.last          = res_last_q;

endmodule

/* design/text_console_renderer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_renderer_unit
// Text console renderer for an 8-pixel-wide glyph framebuffer console.
// ----------------------------------------------------------------------------
// Input channel item: a character to print (kind 0) or one glyph row load
// (kind 1) into the 4096 x 8 glyph store.
// Output channel result: paint, scroll or clear commands, last marking the
// final result of each printed character that gives any result.
// A printable code or backspace gives GLYPH_HEIGHT paint requests, one per
// cycle unless the output stalls, plus one scroll request when the cursor
// wraps off the bottom line; newline gives a scroll or nothing; form feed
// gives one clear. Glyph loads and silent newlines may overlap the last row
// of a cell. After acceptance a job is registered in the row sequencer, then
// passes the read stage and the output register.
// Reset homes the cursor and restores the colour registers; the glyph store
// holds garbage until loaded. A stalled output holds its result, the read
// stage fills and the row sequencer stops; input stays refused until the
// last request of the character in hand has been issued.
// APB: back_color at 0x0, fore_color at 0x4; both are written and read back
// and do not alter any result.
// ----------------------------------------------------------------------------
module text_console_renderer_unit #(
	parameter int SCREEN_PIXELS_WIDE = 1280,
	parameter int SCREEN_PIXELS_HIGH = 720,
	parameter int GLYPH_HEIGHT       = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	tcr_in_if.sink       item,
	tcr_out_if.source    result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int SA = tcr_pkg::CODE_W + tcr_pkg::LINE_W;

	logic          accept, print_take, load_take, seq_start, seq_ready;
	logic          rd_en;
	logic [SA-1:0] rd_addr;
	logic [7:0]    rd_data;
	tcr_pkg::job_t job;
	logic [31:0]   back_color_q, fore_color_q;

	assign item.ready = seq_ready;
	assign accept     = item.valid && item.ready;
	assign print_take = accept && item.kind == tcr_pkg::KIND_PRINT;
	assign load_take  = accept && item.kind == tcr_pkg::KIND_LOAD;
	assign seq_start  = print_take && (job.paint || job.extra);

	tcr_cursor #(
		.SCREEN_PIXELS_WIDE (SCREEN_PIXELS_WIDE),
		.SCREEN_PIXELS_HIGH (SCREEN_PIXELS_HIGH),
		.GLYPH_HEIGHT       (GLYPH_HEIGHT)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (print_take),
		.code   (item.char_code),
		.job    (job)
	);

	tcr_ram #(
		.WIDTH (8),
		.DEPTH (tcr_pkg::STORE_DEPTH)
	) u_glyph_ram (
		.clk   (clk),
		.we    (load_take),
		.waddr ({item.char_code, item.glyph_line}),
		.wdata (item.glyph_bits),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	tcr_seq #(
		.SCREEN_PIXELS_WIDE (SCREEN_PIXELS_WIDE),
		.GLYPH_HEIGHT       (GLYPH_HEIGHT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (seq_start),
		.job       (job),
		.seq_ready (seq_ready),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.result    (result)
	);

	// colour registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_color_q <= 32'h0000_0000;
			fore_color_q <= 32'h00FF_FFFF;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				fore_color_q <= pwdata;
			end else begin
				back_color_q <= pwdata;
			end
		end
	end

	assign prdata = paddr[2] ? fore_color_q : back_color_q;
	assign pready = 1'b1;

endmodule
